// ----- design/mwdiv_pkg.sv -----
// shared constants, beat types and state encoding for the multiword divider
package mwdiv_pkg;

  localparam int LIMB_WIDTH = 64;
  localparam int REM_WIDTH  = 64;
  localparam int CNT_W      = $clog2(REM_WIDTH);

  localparam logic [REM_WIDTH-1:0] DIVISOR_RESET = REM_WIDTH'(1);
  localparam logic [CNT_W-1:0]     LIMB_LAST_IDX = CNT_W'(LIMB_WIDTH - 1);
  localparam logic [CNT_W-1:0]     REM_LAST_IDX  = CNT_W'(REM_WIDTH - 1);

  typedef struct packed {
    logic [63:0] limb;
    logic        last_limb;
  } in_item_t;

  typedef struct packed {
    logic [63:0] quotient_limb;
    logic [63:0] remainder;
    logic        final_item;
  } out_item_t;

  // command to the shift-subtract unit
  typedef struct packed {
    logic                 start;
    logic [REM_WIDTH-1:0] rem;
    logic [REM_WIDTH-1:0] low;
    logic [CNT_W-1:0]     last_idx;
  } core_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ----- design/mwdiv_core.sv -----
// radix-2 restoring divide unit, one quotient bit per cycle
module mwdiv_core import mwdiv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  core_cmd_t             cmd,
  input  logic [REM_WIDTH-1:0]  dvsr,
  output logic                  done,
  output logic [LIMB_WIDTH-1:0] quo,
  output logic [REM_WIDTH-1:0]  rem
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [REM_WIDTH-1:0] low;
  logic [REM_WIDTH-1:0] shifted;
  logic [REM_WIDTH-1:0] diff;
  logic                 take;

  // bring down the next dividend bit, subtract when it fits or the top bit falls out
  assign shifted = {rem[REM_WIDTH-2:0], low[REM_WIDTH-1]};
  assign diff    = shifted - dvsr;
  assign take    = rem[REM_WIDTH-1] | (shifted >= dvsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.last_idx;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= cmd.rem;
      low <= cmd.low;
    end else if (busy) begin
      rem <= take ? diff : shifted;
      low <= {low[REM_WIDTH-2:0], 1'b0};
      quo <= {quo[LIMB_WIDTH-2:0], take};
    end
  end

endmodule

// ----- design/multiword_divide_by_word.sv -----
// top level of the multiword by single word divider
// Divides a multi-limb unsigned number, fed most significant limb first, by the
// 64-bit divisor register (reset value 1). Each input beat yields one output beat
// with the quotient limb and the running remainder; the beat flagged last_limb
// closes the number, carries the final remainder and clears the running
// remainder for the next number. A divisor of zero passes limbs through with a
// remainder of 0. One shared restoring shift-subtract unit resolves one quotient
// bit per cycle; a new limb is accepted only once the previous one has been
// loaded into the output register. If the divisor was rewritten in the middle
// of a number and the running remainder is not below it, a REM_WIDTH-step
// reduction pass on the same unit comes first. A zero divisor bypasses the unit.
// The output beat sits in its own register, so a stalled result does not block
// the next limb from being accepted and worked on. Write the divisor only while
// idle.
module multiword_divide_by_word import mwdiv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [REM_WIDTH-1:0]  divisor;
  logic [REM_WIDTH-1:0]  running_rem;
  logic [LIMB_WIDTH-1:0] limb_hold;
  logic                  last_hold;
  logic                  pass_hold;

  logic                  in_accept;
  logic                  out_free;
  logic                  div_zero;
  logic                  need_reduce;
  logic                  load_out;

  core_cmd_t             cmd;
  logic                  core_done;
  logic [LIMB_WIDTH-1:0] core_quo;
  logic [REM_WIDTH-1:0]  core_rem;

  logic [LIMB_WIDTH-1:0] res_quo;
  logic [REM_WIDTH-1:0]  res_rem;

  // limb left-aligned in the dividend shift register
  logic [REM_WIDTH-1:0]  in_low;
  logic [REM_WIDTH-1:0]  hold_low;

  assign in_low   = REM_WIDTH'(in_item.limb[LIMB_WIDTH-1:0]) << (REM_WIDTH - LIMB_WIDTH);
  assign hold_low = REM_WIDTH'(limb_hold) << (REM_WIDTH - LIMB_WIDTH);

  assign in_stall    = (state != ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign div_zero    = (divisor == '0);
  // divisor lowered mid-number: running remainder must be reduced first
  assign need_reduce = (running_rem >= divisor);

  mwdiv_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .dvsr (divisor),
    .done (core_done),
    .quo  (core_quo),
    .rem  (core_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (div_zero) begin
            state_next = ST_FINISH;
          end else if (need_reduce) begin
            state_next = ST_REDUCE;
          end else begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_REDUCE: begin
        if (core_done) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (core_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs: unit commands and result hand-off
  always_comb begin
    cmd.start    = 1'b0;
    cmd.rem      = running_rem;
    cmd.low      = in_low;
    cmd.last_idx = LIMB_LAST_IDX;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept && !div_zero) begin
          cmd.start = 1'b1;
          if (need_reduce) begin
            // running remainder mod divisor: divide it with a zero upper half
            cmd.rem      = '0;
            cmd.low      = running_rem;
            cmd.last_idx = REM_LAST_IDX;
          end
        end
      end
      ST_REDUCE: begin
        if (core_done) begin
          cmd.start = 1'b1;
          cmd.rem   = core_rem;
          cmd.low   = hold_low;
        end
      end
      ST_DIVIDE: begin
        load_out = 1'b0;
      end
      ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign res_quo = pass_hold ? limb_hold : core_quo;
  assign res_rem = pass_hold ? '0 : core_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      divisor     <= DIVISOR_RESET;
      running_rem <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        divisor <= cfg_data;
      end
      if (load_out) begin
        out_valid   <= 1'b1;
        running_rem <= last_hold ? '0 : res_rem;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      limb_hold <= in_item.limb[LIMB_WIDTH-1:0];
      last_hold <= in_item.last_limb;
      pass_hold <= div_zero;
    end
    if (load_out) begin
      out_item.quotient_limb <= 64'(res_quo);
      out_item.remainder     <= res_rem;
      out_item.final_item    <= last_hold;
    end
  end

endmodule

// ----- tb/multiword_divide_by_word_tb.sv -----
// self-checking testbench for the multiword by single word divider
`timescale 1ns / 1ps

module multiword_divide_by_word_tb;
  import mwdiv_pkg::*;

  localparam logic [63:0] ONES       = ~64'd0;
  localparam logic [63:0] TOP_ONLY   = 64'h8000_0000_0000_0000;
  localparam int          HOLD_BEATS = 400;   // long receiver hold-off, in cycles
  localparam int          SETTLE     = 140;   // settle wait after the final drain, in cycles

  // keeps the divisor and running remainder in step with the block and queues
  // the quotient beat that each accepted limb must produce
  class quotient_board;
    logic [63:0] divisor;
    logic [63:0] carry_rem;
    out_item_t   quotient_q[$];
    int          errors;
    int          checked;
    int          numbers_closed;

    function new();
      divisor        = DIVISOR_RESET;
      carry_rem      = '0;
      errors         = 0;
      checked        = 0;
      numbers_closed = 0;
    endfunction

    function void set_divisor(logic [63:0] value);
      divisor = value;
    endfunction

    function int pending();
      return quotient_q.size();
    endfunction

    // exact (carry * 2^LIMB_WIDTH + limb) / divisor, with the carry brought below
    // the divisor first if it shrank mid-number; a zero divisor passes the limb through
    function void note_input(in_item_t beat);
      logic [63:0]  low_mask;
      logic [63:0]  low;
      logic [63:0]  start;
      logic [127:0] num;
      out_item_t    want;
      low_mask = ONES >> (64 - LIMB_WIDTH);
      low      = beat.limb & low_mask;
      if (divisor == '0) begin
        want.quotient_limb = low;
        want.remainder     = '0;
      end else begin
        start = (carry_rem >= divisor) ? carry_rem % divisor : carry_rem;
        num   = ({64'd0, start} << LIMB_WIDTH) | {64'd0, low};
        want.quotient_limb = 64'(num / {64'd0, divisor}) & low_mask;
        want.remainder     = 64'(num % {64'd0, divisor});
      end
      want.final_item = beat.last_limb;
      carry_rem = beat.last_limb ? '0 : want.remainder;
      quotient_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (quotient_q.size() == 0) begin
        $display("%0t: output beat with nothing expected: q=%h r=%h last=%b",
                 $time, got.quotient_limb, got.remainder, got.final_item);
        errors++;
        return;
      end
      want = quotient_q.pop_front();
      checked++;
      if (want.final_item) numbers_closed++;
      if (got.quotient_limb !== want.quotient_limb) begin
        $display("%0t: quotient_limb expected %h actual %h",
                 $time, want.quotient_limb, got.quotient_limb);
        errors++;
      end
      if (got.remainder !== want.remainder) begin
        $display("%0t: remainder expected %h actual %h",
                 $time, want.remainder, got.remainder);
        errors++;
      end
      if (got.final_item !== want.final_item) begin
        $display("%0t: final_item expected %b actual %b",
                 $time, want.final_item, got.final_item);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;

  quotient_board board;

  // idle rates in percent, changed per stimulus mode
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // hold-off request from the stimulus, served and counted by the receiver
  logic hold_request = 1'b0;
  int   hold_left = 0;

  int limbs_sent = 0;
  int divisor_writes = 0;

  always #10 clk = ~clk;

  multiword_divide_by_word DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // receiver: checks each accepted result beat, then picks next cycle's stall;
  // a pending hold-off request turns into a long solid stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_item);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_request) begin
        out_stall    <= 1'b1;
        hold_left    <= HOLD_BEATS;
        hold_request <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  function automatic in_item_t make_beat(logic [63:0] value, logic last);
    in_item_t beat;
    beat.limb      = value;
    beat.last_limb = last;
    return beat;
  endfunction

  // limbs lean toward the edges: zero, all ones, single bits
  function automatic logic [63:0] pick_limb();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ONES;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // divisors: pass-through, one, extremes, powers of two, small and random widths
  function automatic logic [63:0] pick_divisor();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 64'd1;
      2:       return ONES;
      3:       return 64'd1 << $urandom_range(63);
      4:       return 64'($urandom_range(1000, 2));
      5:       return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one beat, with a random idle gap first, and wait for acceptance
  task automatic send_limb(in_item_t beat);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (in_stall);
    board.note_input(beat);
    limbs_sent++;
  endtask

  // one number of the given length; an open number is left without its last limb
  task automatic send_number(int len, bit open);
    for (int i = 0; i < len; i++)
      send_limb(make_beat(pick_limb(), (i == len - 1) && !open));
  endtask

  // stop offering and wait until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // divisor write, only ever called with the block idle
  task automatic write_divisor(logic [63:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_divisor(value);
    divisor_writes++;
  endtask

  initial begin
    int phase_len;
    int sent_here;
    int len;
    bit open;

    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset divisor of one: quotient is the limb, remainder stays zero
    send_limb(make_beat(ONES, 1'b0));
    send_limb(make_beat('0, 1'b1));

    // zero divisor passes limbs through
    drain_results();
    write_divisor('0);
    send_limb(make_beat(ONES, 1'b0));
    send_limb(make_beat(64'h0123_4567_89ab_cdef, 1'b1));

    // largest divisor, limbs at both extremes
    drain_results();
    write_divisor(ONES);
    send_limb(make_beat(ONES, 1'b0));
    send_limb(make_beat(ONES, 1'b0));
    send_limb(make_beat('0, 1'b1));
    send_limb(make_beat(ONES - 1, 1'b1));

    // top bit only: divisor with just the top bit set, the largest power of two
    drain_results();
    write_divisor(TOP_ONLY);
    send_limb(make_beat(ONES, 1'b0));
    send_limb(make_beat(TOP_ONLY, 1'b0));
    send_limb(make_beat(64'd1, 1'b1));

    drain_results();
    write_divisor(64'd3);
    send_limb(make_beat(ONES, 1'b0));
    send_limb(make_beat(ONES, 1'b1));
    send_limb(make_beat(64'd2, 1'b1));

    // divisor shrinks mid-number: running remainder needs reducing first
    drain_results();
    write_divisor(ONES);
    send_limb(make_beat(ONES - 1, 1'b0));
    drain_results();
    write_divisor(64'd7);
    send_limb(make_beat(64'd5, 1'b1));

    // zero divisor mid-number drops the running remainder
    drain_results();
    write_divisor(64'd1000);
    send_limb(make_beat(ONES, 1'b0));
    drain_results();
    write_divisor('0);
    send_limb(make_beat(64'd42, 1'b0));
    drain_results();
    write_divisor(64'd9);
    send_limb(make_beat(ONES, 1'b1));

    // random numbers in three idle modes, about 300 limbs each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin snd_idle_pct = 8;  rcv_idle_pct = 61; end
        1: begin snd_idle_pct = 61; rcv_idle_pct = 8;  end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      sent_here = 0;
      while (sent_here < 300) begin
        // the sender pauses here until every result is back
        drain_results();
        write_divisor(pick_divisor());
        // first phase of the first mode: receiver holds off while the sender keeps offering limbs
        if (mode == 0 && sent_here == 0) hold_request <= 1'b1;
        phase_len = $urandom_range(60, 20);
        for (int n = 0; n < phase_len; n += len) begin
          len  = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
          // sometimes the number is cut off by the next divisor change
          open = (n + len >= phase_len) && ($urandom_range(3) == 0);
          send_number(len, open);
          sent_here += len;
        end
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d limbs in %0d numbers across %0d divisor writes,",
             limbs_sent, board.numbers_closed, divisor_writes);
    $display("with pass-through, mid-number divisor changes and a long output hold-off");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("multiword_divide_by_word: match");
    end else begin
      $display("multiword_divide_by_word: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", board.pending());
    $display("multiword_divide_by_word: mismatch");
    $finish;
  end

endmodule
